// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, off while reset is low.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Concurrent assertion sampled on the rising clock edge, always on.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== hw/rtl/lkvc_pkg.sv =====
package lkvc_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AGE_W   = IDX_W;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 4;

  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(8);
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_STORE  = 1'b1;

endpackage

// ===== hw/rtl/lru_key_value_cache.sv =====
// Fully associative key/value cache with LRU replacement, 8 entries. Each
// request (tuser = 0 lookup, 1 store) yields one response: tuser = found, and
// tdata = stored value on a lookup hit, else all ones. The block takes one
// transaction per clock while the response is not stalled. A request is
// held in the input register, then all keys are compared and all age ranks
// updated combinationally into the response register, which presents the
// response. A stalled response holds the input register, so at most two
// requests are in flight. The capacity register (1..8, 0 acts as 1, above 8
// acts as 8) may only be written while no request is in flight; lowering it
// evicts nothing at once. The valid bits clear at reset, so the cache is
// usable right away.
module lru_key_value_cache
  import lkvc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     cfg_we_i,
  input  logic [CAP_W-1:0]         cfg_wdata_i,     // capacity

  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [KEY_W+VAL_W-1:0]   s_axis_tdata_i,  // [31:0] key, [63:32] value
  input  logic                     s_axis_tuser_i,  // [0] cmd

  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [VAL_W-1:0]         m_axis_tdata_o,  // [31:0] read_value
  output logic                     m_axis_tuser_o   // [0] found
);

  logic [CAP_W-1:0] cap_q;

  logic             in_vld_q;
  logic             in_cmd_q;
  logic [KEY_W-1:0] in_key_q;
  logic [VAL_W-1:0] in_val_q;

  logic             out_vld_q;
  logic             out_found_q, out_found_d;
  logic [VAL_W-1:0] out_data_q, out_data_d;

  logic [ENTRIES-1:0]            valid_q, valid_d;
  logic [ENTRIES-1:0][AGE_W-1:0] age_q, age_d;
  logic [CNT_W-1:0]              used_q, used_d;
  logic [KEY_W-1:0]              key_mem [ENTRIES];
  logic [VAL_W-1:0]              val_mem [ENTRIES];

  logic             in_acc;
  logic             advance;

  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             has_free;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] victim_idx;
  logic [AGE_W-1:0] oldest_age;
  logic [CNT_W-1:0] eff_cap;
  logic             full;

  logic             touch_en;
  logic [IDX_W-1:0] touch_idx;
  logic             wr_en;
  logic             wr_key;
  logic [IDX_W-1:0] wr_idx;

  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (int'(cap_q) > ENTRIES) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap_q);
    end
  end

  assign full       = used_q >= eff_cap;
  assign oldest_age = AGE_W'(used_q - CNT_W'(1));

  // Keys are unique among valid entries, so at most one matches.
  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    has_free   = 1'b0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && key_mem[i] == in_key_q) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        has_free = 1'b1;
        free_idx = IDX_W'(i);
      end
      // Valid ranks are distinct 0..used-1, so the oldest holds used-1.
      if (valid_q[i] && age_q[i] == oldest_age) begin
        victim_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_d     = valid_q;
    age_d       = age_q;
    used_d      = used_q;
    touch_en    = 1'b0;
    touch_idx   = hit_idx;
    wr_en       = 1'b0;
    wr_key      = 1'b0;
    wr_idx      = hit_idx;
    out_found_d = hit;
    out_data_d  = MISS_VALUE;

    if (hit) begin
      touch_en = 1'b1;
      if (in_cmd_q == CMD_LOOKUP) begin
        out_data_d = val_mem[hit_idx];
      end else begin
        wr_en = 1'b1;
      end
    end else if (in_cmd_q == CMD_STORE) begin
      if (full) begin
        // Evict the least recent entry and reuse its slot.
        touch_en  = 1'b1;
        touch_idx = victim_idx;
        wr_en     = 1'b1;
        wr_key    = 1'b1;
        wr_idx    = victim_idx;
      end else if (has_free) begin
        wr_en  = 1'b1;
        wr_key = 1'b1;
        wr_idx = free_idx;
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i]) begin
            age_d[i] = age_q[i] + AGE_W'(1);
          end
        end
        valid_d[free_idx] = 1'b1;
        age_d[free_idx]   = '0;
        used_d            = used_q + CNT_W'(1);
      end
    end

    if (touch_en) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && age_q[i] < age_q[touch_idx]) begin
          age_d[i] = age_q[i] + AGE_W'(1);
        end
      end
      age_d[touch_idx] = '0;
    end

    if (!advance) begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      valid_q   <= '0;
      age_q     <= '0;
      used_q    <= '0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        valid_q   <= valid_d;
        age_q     <= age_d;
        used_q    <= used_d;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_cmd_q <= s_axis_tuser_i;
      in_key_q <= s_axis_tdata_i[KEY_W-1:0];
      in_val_q <= s_axis_tdata_i[KEY_W+VAL_W-1:KEY_W];
    end
    if (advance) begin
      out_found_q <= out_found_d;
      out_data_q  <= out_data_d;
    end
    if (wr_en) begin
      val_mem[wr_idx] <= in_val_q;
      if (wr_key) begin
        key_mem[wr_idx] <= in_key_q;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_found_q;

endmodule

// ===== hw/rtl/lkvc_checker.sv =====
`include "assert_macros.svh"

module lkvc_checker
  import lkvc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_o,
  input  logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  input  logic [VAL_W-1:0]       m_axis_tdata_o,
  input  logic                   m_axis_tuser_o
);

  logic           in_acc;
  logic           out_stall;
  logic           out_miss;
  logic [VAL_W:0] out_bus;

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_miss  = m_axis_tvalid_o && !m_axis_tuser_o;
  assign out_bus   = {m_axis_tuser_o, m_axis_tdata_o};

  // Hold a stalled response.
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, out_stall |=> m_axis_tvalid_o && $stable(out_bus))

  // A miss always reads back all ones.
  `ASSERT_RST(a_miss_value, clk_i, rst_ni, out_miss |-> m_axis_tdata_o == MISS_VALUE)

  // Backpressure on the input only comes from a stalled output.
  `ASSERT_RST(a_ready_cause, clk_i, rst_ni, !s_axis_tready_o |-> out_stall)

  // A response after an empty output stems from a transaction that went through the input register unstalled.
  `ASSERT_RST(a_latency, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> $past(in_acc, 2))

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);
